// ===== rtl/core/cpd_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the command packet deframer.
// No dependencies; every other file of the block imports this package.
package cpd_pkg;

	localparam int ADDR_W = 3;      // two 32-bit registers at byte addresses 0 and 4
	localparam int DATA_W = 32;
	localparam int CNT_W  = 5;

	localparam logic [CNT_W-1:0] PKT_LEN   = 5'd23;  // bytes in a full packet
	localparam logic [CNT_W-1:0] CRC_END   = 5'd21;  // CRC covers bytes 0..20
	localparam logic [CNT_W-1:0] IDX_START0 = 5'd0;
	localparam logic [CNT_W-1:0] IDX_START1 = 5'd1;
	localparam logic [CNT_W-1:0] IDX_CMD    = 5'd4;
	localparam logic [CNT_W-1:0] IDX_LEN_HI = 5'd7;
	localparam logic [CNT_W-1:0] IDX_LEN_LO = 5'd8;
	localparam logic [CNT_W-1:0] IDX_PAY    = 5'd9;
	localparam logic [CNT_W-1:0] IDX_CRC_HI = 5'd21;
	localparam logic [CNT_W-1:0] IDX_CRC_LO = 5'd22;

	localparam int PAY_WORDS = 3;
	localparam int PAY_BYTES = 4 * PAY_WORDS;

	localparam logic [7:0]  PAYLOAD_LEN = 8'd12;  // required value of the length field
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [7:0]  START_RESET = 8'h99;
	localparam logic [7:0]  CMD_RESET   = 8'd78;

	typedef enum logic [0:0] {
		REG_START_BYTE = 1'b0,
		REG_EXP_CMD    = 1'b1
	} cpd_reg_e;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_BAD_START = 3'd2,
		ST_BAD_CMD   = 3'd3,
		ST_BAD_LEN   = 3'd4,
		ST_BAD_CRC   = 3'd5
	} cpd_status_e;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] expected_command;
	} cpd_cfg_t;

	// CRC-16 CCITT, MSB first, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/cpd_if.sv =====
// Byte request channel and result channel of the command packet deframer.
// Depends on cpd_pkg.
interface cpd_pkt_if;
	import cpd_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, data_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface cpd_rsp_if;
	import cpd_pkg::*;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] x_bits;
	logic [31:0] y_bits;
	logic [31:0] z_bits;
	modport source (output valid, status, x_bits, y_bits, z_bits, input ready);
	modport sink   (input valid, status, x_bits, y_bits, z_bits, output ready);
endinterface

// ===== rtl/core/cpd_apb_regs.sv =====
// APB register file: start byte and expected command.
// Depends on cpd_pkg.
module cpd_apb_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cpd_pkg::ADDR_W-1:0] paddr,
	input  logic [cpd_pkg::DATA_W-1:0] pwdata,
	output logic [cpd_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output cpd_pkg::cpd_cfg_t          cfg
);
	import cpd_pkg::*;

	cpd_cfg_t cfg_q;
	cpd_reg_e sel;
	logic     wr_en;

	assign sel    = cpd_reg_e'(paddr[2]);   // byte-lane bits ignored
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte       <= START_RESET;
			cfg_q.expected_command <= CMD_RESET;
		end else if (wr_en) begin
			case (sel)
				REG_START_BYTE: cfg_q.start_byte       <= pwdata[7:0];
				REG_EXP_CMD:    cfg_q.expected_command <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_START_BYTE: prdata = {24'd0, cfg_q.start_byte};
			REG_EXP_CMD:    prdata = {24'd0, cfg_q.expected_command};
			default:        prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/command_packet_deframer_crc16_top.sv =====
// Command packet deframer with CRC-16 check: top level.
// Depends on cpd_pkg, cpd_if (cpd_pkt_if, cpd_rsp_if) and cpd_apb_regs.

// Takes a packet one byte per request on pkt, with last_byte marking the final
// byte. Bytes 0 and 1 must equal the start_byte register, byte 4 the
// expected_command register, and bytes 7..8 a big-endian length of 12. A
// CRC-16 CCITT (poly 0x1021, init 0, MSB first, no final xor) over bytes 0..20
// is compared with the big-endian CRC in bytes 21..22. Bytes 9..20 come out as
// three little-endian 32-bit words (x, y, z). One result request per packet,
// on rsp, after the last byte: status 0 ok, 1 too short, 2 bad start, 3 bad
// command, 4 bad length, 5 CRC mismatch, lowest code winning; the words are
// zero on any error. Bytes past byte 22 are ignored. Rate: one byte per cycle.
// A byte is held in the input register, then the per-byte update (CRC byte
// step, checks, word capture) runs in one pass into the packet state; a
// result goes into the output register as its last byte leaves the input.
// The input stalls only when a last byte meets a result that is still unread.
// Registers sit at APB byte addresses 0 (start_byte) and 4 (expected_command);
// the user must make writes with the packet path idle; the block does not enforce it.
module command_packet_deframer_crc16_top (
	input  logic                       clk,
	input  logic                       arst_n,
	cpd_pkt_if.sink                    pkt,
	cpd_rsp_if.source                  rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cpd_pkg::ADDR_W-1:0] paddr,
	input  logic [cpd_pkg::DATA_W-1:0] pwdata,
	output logic [cpd_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import cpd_pkg::*;

	cpd_cfg_t cfg;

	cpd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ---------------- input register ----------------
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       accept;
	logic       go;          // stage-1 byte is consumed this cycle

	// ---------------- packet state ----------------
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      crc_q;
	logic [15:0]      rx_crc_q;
	logic             start_err_q;
	logic             cmd_err_q;
	logic             len_err_q;
	logic [31:0]      words_q [PAY_WORDS];

	// next-state values with the stage-1 byte folded in
	logic [CNT_W-1:0] cnt_n;
	logic [15:0]      crc_n;
	logic [15:0]      rx_crc_n;
	logic             start_err_n;
	logic             cmd_err_n;
	logic             len_err_n;
	logic [31:0]      words_n [PAY_WORDS];
	logic             live;
	cpd_status_e      status_n;

	// ---------------- result register ----------------
	logic        rsp_vld_q;
	cpd_status_e status_q;
	logic [31:0] x_q;
	logic [31:0] y_q;
	logic [31:0] z_q;

	// A last byte needs the result register free (or being drained).
	assign go     = vld_s1 && (!last_s1 || !rsp_vld_q || rsp.ready);
	assign accept = pkt.valid && pkt.ready;
	assign pkt.ready = !vld_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (go) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= pkt.data_byte;
			last_s1 <= pkt.last_byte;
		end
	end

	// Per-byte update: every check keys off the current byte position.
	always_comb begin
		live        = cnt_q < PKT_LEN;
		cnt_n       = live ? cnt_q + 5'd1 : cnt_q;   // saturates at 23
		crc_n       = crc_q;
		rx_crc_n    = rx_crc_q;
		start_err_n = start_err_q;
		cmd_err_n   = cmd_err_q;
		len_err_n   = len_err_q;
		for (int w = 0; w < PAY_WORDS; w++) begin
			words_n[w] = words_q[w];
		end

		if (live && cnt_q < CRC_END) begin
			crc_n = crc16_byte(crc_q, byte_s1);
		end
		if ((cnt_q == IDX_START0 || cnt_q == IDX_START1) && byte_s1 != cfg.start_byte) begin
			start_err_n = 1'b1;
		end
		if (cnt_q == IDX_CMD && byte_s1 != cfg.expected_command) begin
			cmd_err_n = 1'b1;
		end
		if (cnt_q == IDX_LEN_HI && byte_s1 != 8'd0) begin
			len_err_n = 1'b1;
		end
		if (cnt_q == IDX_LEN_LO && byte_s1 != PAYLOAD_LEN) begin
			len_err_n = 1'b1;
		end
		// little-endian capture of the three payload words
		for (int k = 0; k < PAY_BYTES; k++) begin
			if (cnt_q == IDX_PAY + CNT_W'(k)) begin
				words_n[k / 4][(k % 4) * 8 +: 8] = byte_s1;
			end
		end
		if (cnt_q == IDX_CRC_HI) begin
			rx_crc_n[15:8] = byte_s1;
		end
		if (cnt_q == IDX_CRC_LO) begin
			rx_crc_n[7:0] = byte_s1;
		end

		// priority: short, start, command, length, CRC
		if (cnt_n < PKT_LEN) begin
			status_n = ST_SHORT;
		end else if (start_err_n) begin
			status_n = ST_BAD_START;
		end else if (cmd_err_n) begin
			status_n = ST_BAD_CMD;
		end else if (len_err_n) begin
			status_n = ST_BAD_LEN;
		end else if (crc_n != rx_crc_n) begin
			status_n = ST_BAD_CRC;
		end else begin
			status_n = ST_OK;
		end
	end

	// Packet state: loads the update, or clears after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			crc_q       <= '0;
			rx_crc_q    <= '0;
			start_err_q <= 1'b0;
			cmd_err_q   <= 1'b0;
			len_err_q   <= 1'b0;
			for (int w = 0; w < PAY_WORDS; w++) begin
				words_q[w] <= '0;
			end
		end else if (go) begin
			if (last_s1) begin
				cnt_q       <= '0;
				crc_q       <= '0;
				rx_crc_q    <= '0;
				start_err_q <= 1'b0;
				cmd_err_q   <= 1'b0;
				len_err_q   <= 1'b0;
				for (int w = 0; w < PAY_WORDS; w++) begin
					words_q[w] <= '0;
				end
			end else begin
				cnt_q       <= cnt_n;
				crc_q       <= crc_n;
				rx_crc_q    <= rx_crc_n;
				start_err_q <= start_err_n;
				cmd_err_q   <= cmd_err_n;
				len_err_q   <= len_err_n;
				for (int w = 0; w < PAY_WORDS; w++) begin
					words_q[w] <= words_n[w];
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (go && last_s1) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && last_s1) begin
			status_q <= status_n;
			x_q      <= (status_n == ST_OK) ? words_n[0] : 32'd0;
			y_q      <= (status_n == ST_OK) ? words_n[1] : 32'd0;
			z_q      <= (status_n == ST_OK) ? words_n[2] : 32'd0;
		end
	end

	assign rsp.valid  = rsp_vld_q;
	assign rsp.status = status_q;
	assign rsp.x_bits = x_q;
	assign rsp.y_bits = y_q;
	assign rsp.z_bits = z_q;

	// ---------------- assertions ----------------
	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= PKT_LEN)
		else $error("byte counter beyond packet length");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		go && last_s1 |=> cnt_q == '0 && crc_q == '0 && !start_err_q)
		else $error("packet state not cleared after last byte");

	a_last_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		go && last_s1 |=> rsp_vld_q && status_q == $past(status_n))
		else $error("last byte did not load a result");

	a_err_zero_words: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && status_q != ST_OK |-> x_q == '0 && y_q == '0 && z_q == '0)
		else $error("payload words not zeroed on failed packet");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && !rsp.ready |-> !(go && last_s1))
		else $error("unread result overwritten");

endmodule

// ===== tb/sv/deframer_frame_pkg.sv =====
// Testbench types for the command packet deframer: the decoded frame record and a CRC-16 step.
// Depends on cpd_pkg. Used by deframer_checker and the test top.
`timescale 1ns / 1ps
package deframer_frame_pkg;
	import cpd_pkg::*;

	typedef struct {
		cpd_status_e status;
		logic [31:0] x_bits;
		logic [31:0] y_bits;
		logic [31:0] z_bits;
	} frame_result_t;

	// CCITT poly, MSB first, one bit per turn
	function automatic logic [15:0] crc16_ccitt_step(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		logic fb;
		r = acc;
		for (int k = 7; k >= 0; k--) begin
			fb = r[15] ^ b[k];
			r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return r;
	endfunction

endpackage

// ===== tb/sv/deframer_checker.sv =====
// Watches the byte and result channels and the APB writes, predicts each frame status and words.
// Depends on cpd_pkg, cpd_if and deframer_frame_pkg.
`timescale 1ns / 1ps
module deframer_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	cpd_pkt_if                         pkt_mon,
	cpd_rsp_if                         rsp_mon,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [cpd_pkg::ADDR_W-1:0] paddr,
	input  logic [cpd_pkg::DATA_W-1:0] pwdata,
	output int                         outstanding,
	output int                         mismatches
);
	import cpd_pkg::*;
	import deframer_frame_pkg::*;

	logic [7:0]       start_cfg;
	logic [7:0]       cmd_cfg;
	logic [CNT_W-1:0] count;
	logic [15:0]      crc_acc;
	logic [15:0]      crc_rx;
	logic             start_err;
	logic             cmd_err;
	logic             len_err;
	logic [31:0]      words [PAY_WORDS];
	frame_result_t    frames_due [$];
	frame_result_t    due;

	task automatic clear_frame();
		count = '0;
		crc_acc = '0;
		crc_rx = '0;
		start_err = 1'b0;
		cmd_err = 1'b0;
		len_err = 1'b0;
		for (int w = 0; w < PAY_WORDS; w++) words[w] = '0;
	endtask

	// per-byte update; on the last byte the decoded frame is queued
	task automatic absorb_byte(input logic [7:0] b, input logic lst);
		frame_result_t r;
		int off;
		if (count < PKT_LEN) begin
			if (count < CRC_END) crc_acc = crc16_ccitt_step(crc_acc, b);
			if ((count == IDX_START0 || count == IDX_START1) && b != start_cfg) start_err = 1'b1;
			if (count == IDX_CMD && b != cmd_cfg) cmd_err = 1'b1;
			if (count == IDX_LEN_HI && b != 8'd0) len_err = 1'b1;
			if (count == IDX_LEN_LO && b != PAYLOAD_LEN) len_err = 1'b1;
			if (count >= IDX_PAY && count < CRC_END) begin
				off = int'(count) - int'(IDX_PAY);
				words[off / 4][8 * (off % 4) +: 8] = b;
			end
			if (count == IDX_CRC_HI) crc_rx[15:8] = b;
			if (count == IDX_CRC_LO) crc_rx[7:0] = b;
			count = count + 1'b1;
		end
		if (lst) begin
			if (count < PKT_LEN) r.status = ST_SHORT;
			else if (start_err) r.status = ST_BAD_START;
			else if (cmd_err) r.status = ST_BAD_CMD;
			else if (len_err) r.status = ST_BAD_LEN;
			else if (crc_acc != crc_rx) r.status = ST_BAD_CRC;
			else r.status = ST_OK;
			r.x_bits = (r.status == ST_OK) ? words[0] : '0;
			r.y_bits = (r.status == ST_OK) ? words[1] : '0;
			r.z_bits = (r.status == ST_OK) ? words[2] : '0;
			frames_due.push_back(r);
			clear_frame();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		start_cfg = START_RESET;
		cmd_cfg = CMD_RESET;
		outstanding = 0;
		mismatches = 0;
		clear_frame();
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
				case (cpd_reg_e'(paddr[ADDR_W-1:2]))
					REG_START_BYTE: start_cfg = pwdata[7:0];
					REG_EXP_CMD:    cmd_cfg = pwdata[7:0];
					default: ;
				endcase
			end
			if (pkt_mon.valid && pkt_mon.ready) absorb_byte(pkt_mon.data_byte, pkt_mon.last_byte);
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (frames_due.size() == 0) begin
					$error("result with no frame pending: status %0d", rsp_mon.status);
					mismatches++;
				end else begin
					due = frames_due.pop_front();
					check_field("status", 32'(due.status), 32'(rsp_mon.status));
					check_field("x_bits", due.x_bits, rsp_mon.x_bits);
					check_field("y_bits", due.y_bits, rsp_mon.y_bits);
					check_field("z_bits", due.z_bits, rsp_mon.z_bits);
				end
			end
			outstanding = frames_due.size();
		end
	end

endmodule

// ===== tb/sv/command_packet_deframer_crc16_top_test.sv =====
// Test top for the command packet deframer: clock, reset, byte and APB stimulus, verdict.
// Depends on cpd_pkg, cpd_if, deframer_frame_pkg, deframer_checker and the block's top.
`timescale 1ns / 1ps
module command_packet_deframer_crc16_top_test;
	import cpd_pkg::*;
	import deframer_frame_pkg::*;

	localparam int LIMIT        = 400000;  // watchdog, far above the slowest legal run
	localparam int HOLD_CYCLES  = 300;     // long result hold-off, fills the block
	localparam int PHASE_BYTES  = 120;
	localparam int PHASE_FRAMES = 6;
	localparam int MAX_FRAME    = 34;      // longest frame sent (long and noise frames)
	localparam int SETTLE       = 8;       // block latency plus margin

	// frame shapes; every shape but good breaks exactly what its name says,
	// except multi (several faults, priority) and noise (random bytes)
	typedef enum int {
		FR_GOOD,
		FR_SHORT,
		FR_BAD_START,
		FR_BAD_CMD,
		FR_BAD_LEN,
		FR_BAD_CRC,
		FR_LONG,
		FR_MULTI,
		FR_NOISE
	} frame_kind_e;
	localparam int N_FAULTS = 8;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int outstanding;
	int mismatches;
	int cycle_count = 0;
	int send_idle_pct = 0;  // chance in 100 that the sender pauses before a byte
	int stall_pct = 0;      // chance in 100 that the receiver drops ready in a cycle
	int hold_trigger = 0;   // bumped to ask the receiver for one long hold-off
	int sent_bytes = 0;
	int sent_frames = 0;

	logic [7:0] cur_start;  // register values as last written, to build frames
	logic [7:0] cur_cmd;

	cpd_pkt_if byte_req();
	cpd_rsp_if frame_rsp();

	command_packet_deframer_crc16_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pkt     (byte_req),
		.rsp     (frame_rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	deframer_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.pkt_mon     (byte_req),
		.rsp_mon     (frame_rsp),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin : watchdog
		wait (cycle_count >= LIMIT);
		$display("tb: failure");
		$finish;
	end

	// Result side. Ready changes on the falling edge only. A bump of
	// hold_trigger gets one long hold-off, counted here, while the sender
	// keeps offering bytes.
	initial begin : receiver
		int hold_served;
		hold_served = 0;
		frame_rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_trigger) begin
				hold_served = hold_trigger;
				frame_rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			frame_rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// One byte request. Called on a falling edge, returns on the falling edge
	// after acceptance with valid still high; the caller lowers it when the
	// stream stops.
	task automatic send_byte(input logic [7:0] b, input logic lst);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			byte_req.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		byte_req.valid <= 1'b1;
		byte_req.data_byte <= b;
		byte_req.last_byte <= lst;
		@(posedge clk);
		while (!byte_req.ready) @(posedge clk);
		@(negedge clk);
		sent_bytes++;
	endtask

	// Builds one frame against the current registers and sends it.
	// fill < 0: random content, else every free byte takes that value.
	task automatic send_frame(input frame_kind_e kind, input int fill);
		logic [7:0]  fb [0:MAX_FRAME-1];
		logic [15:0] crc;
		int          len;
		int          pick;
		for (int i = 0; i < MAX_FRAME; i++) fb[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
		len = int'(PKT_LEN);
		fb[IDX_START0] = cur_start;
		fb[IDX_START1] = cur_start;
		fb[IDX_CMD] = cur_cmd;
		fb[IDX_LEN_HI] = 8'd0;
		fb[IDX_LEN_LO] = PAYLOAD_LEN;
		// header faults go in before the CRC so the CRC itself stays right
		case (kind)
			FR_BAD_START: begin
				pick = $urandom_range(IDX_START0, IDX_START1);
				fb[pick] = fb[pick] ^ 8'($urandom_range(1, 255));
			end
			FR_BAD_CMD: fb[IDX_CMD] = fb[IDX_CMD] ^ 8'($urandom_range(1, 255));
			FR_BAD_LEN: begin
				pick = $urandom_range(IDX_LEN_HI, IDX_LEN_LO);
				fb[pick] = fb[pick] ^ 8'($urandom_range(1, 255));
			end
			default: ;
		endcase
		crc = '0;
		for (int i = 0; i < CRC_END; i++) crc = crc16_ccitt_step(crc, fb[i]);
		fb[IDX_CRC_HI] = crc[15:8];
		fb[IDX_CRC_LO] = crc[7:0];
		case (kind)
			FR_SHORT: len = $urandom_range(1, PKT_LEN - 1);
			FR_BAD_CRC: begin
				pick = $urandom_range(IDX_CRC_HI, IDX_CRC_LO);
				fb[pick] = fb[pick] ^ 8'($urandom_range(1, 255));
			end
			FR_LONG: len = $urandom_range(PKT_LEN + 1, MAX_FRAME);
			FR_MULTI: begin
				// one header byte and one CRC byte, sometimes cut short as well
				case ($urandom_range(0, 4))
					0: pick = IDX_START0;
					1: pick = IDX_START1;
					2: pick = IDX_CMD;
					3: pick = IDX_LEN_HI;
					default: pick = IDX_LEN_LO;
				endcase
				fb[pick] = fb[pick] ^ 8'($urandom_range(1, 255));
				pick = $urandom_range(IDX_CRC_HI, IDX_CRC_LO);
				fb[pick] = fb[pick] ^ 8'($urandom_range(1, 255));
				if ($urandom_range(0, 2) == 0) len = $urandom_range(1, PKT_LEN - 1);
			end
			FR_NOISE: begin
				for (int i = 0; i < MAX_FRAME; i++) fb[i] = 8'($urandom);
				len = $urandom_range(1, MAX_FRAME);
			end
			default: ;
		endcase
		for (int i = 0; i < len; i++) send_byte(fb[i], i == len - 1);
		sent_frames++;
	endtask

	// APB write: setup then access, waits on pready
	task automatic write_reg(input cpd_reg_e r, input logic [7:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= {24'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// registers change only with no frame in flight and the pipe drained
	task automatic apply_config(input logic [7:0] s, input logic [7:0] c);
		wait (outstanding == 0);
		repeat (SETTLE) @(negedge clk);
		write_reg(REG_START_BYTE, s);
		write_reg(REG_EXP_CMD, c);
		cur_start = s;
		cur_cmd = c;
	endtask

	initial begin : stimulus
		frame_kind_e kind;
		int phase_bytes;
		int phase_frames;
		arst_n = 1'b0;
		byte_req.valid = 1'b0;
		byte_req.data_byte = 8'd0;
		byte_req.last_byte = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cur_start = START_RESET;
		cur_cmd = CMD_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: a lone all-ones byte (too short and bad start at once,
		// short must win), then a clean frame with every free byte all ones
		send_byte(8'hFF, 1'b1);
		send_frame(FR_GOOD, 8'hFF);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
					hold_trigger = hold_trigger + 1;  // result side freezes, input backs up
				end
				1: begin
					apply_config(8'h00, 8'h00);
					send_idle_pct = 73;
					stall_pct = 0;
				end
				2: begin
					apply_config(8'hFF, 8'hFF);
					send_idle_pct = 0;
					stall_pct = 73;
				end
				default: begin
					apply_config(8'($urandom), 8'($urandom));
					send_idle_pct = 30;
					stall_pct = 30;
				end
			endcase
			phase_bytes = sent_bytes;
			phase_frames = sent_frames;
			// every other frame is clean; faulty ones walk through all shapes
			while (sent_bytes - phase_bytes < PHASE_BYTES || sent_frames - phase_frames < PHASE_FRAMES)
				begin
				if (sent_frames % 2 == 0) kind = FR_GOOD;
				else kind = frame_kind_e'(1 + (sent_frames / 2) % N_FAULTS);
				send_frame(kind, -1);
			end
			byte_req.valid <= 1'b0;
		end

		wait (outstanding == 0);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
